// ===== rtl/core/sasm_pkg.sv =====
package sasm_pkg;

  localparam int MSG_W     = 4;
  localparam int ACTION_W  = 4;
  localparam int PHASE_W   = 2;
  localparam int SESSION_W = 32;
  localparam int CLIENT_W  = 32;
  localparam int CODEC_W   = 8;
  localparam int TIME_W    = 64;
  localparam int TIMEOUT_W = 32;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODEC_MASK = 2'd1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET    = 32'd5000000;
  localparam logic [CODEC_W-1:0]   CODEC_MASK_RESET = 8'd1;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE   = 2'd0,
    PH_READY  = 2'd1,
    PH_STREAM = 2'd2
  } phase_t;

  typedef enum logic [MSG_W-1:0] {
    MSG_HELLO      = 4'd0,
    MSG_START      = 4'd1,
    MSG_PING       = 4'd2,
    MSG_KEYFRAME   = 4'd3,
    MSG_INPUT      = 4'd4,
    MSG_FOCUS      = 4'd5,
    MSG_FEEDBACK   = 4'd6,
    MSG_NACK       = 4'd7,
    MSG_INVALIDATE = 4'd8,
    MSG_CLIPBOARD  = 4'd9,
    MSG_BYE        = 4'd10
  } msg_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE       = 4'd0,
    ACT_ACK        = 4'd1,
    ACT_REJECT     = 4'd2,
    ACT_PONG       = 4'd3,
    ACT_START      = 4'd4,
    ACT_KEYFRAME   = 4'd5,
    ACT_INPUT      = 4'd6,
    ACT_FOCUS      = 4'd7,
    ACT_FEEDBACK   = 4'd8,
    ACT_NACK       = 4'd9,
    ACT_INVALIDATE = 4'd10,
    ACT_CLIPBOARD  = 4'd11,
    ACT_DISC       = 4'd12
  } action_t;

  typedef struct packed {
    logic                 operation;
    logic [MSG_W-1:0]     msg_type;
    logic                 header_ok;
    logic                 payload_ok;
    logic [SESSION_W-1:0] packet_session;
    logic [CLIENT_W-1:0]  client_ident;
    logic [CODEC_W-1:0]   codec_bits;
    logic [TIME_W-1:0]    now_us;
  } item_t;

  typedef struct packed {
    logic                 accepted;
    action_t              action;
    logic [SESSION_W-1:0] current_session;
    phase_t               phase;
  } result_t;

  typedef struct packed {
    phase_t               phase;
    logic [SESSION_W-1:0] session;
    logic [CLIENT_W-1:0]  client;
    logic [TIME_W-1:0]    last_rx;
  } session_state_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_us;
    logic [CODEC_W-1:0]   codec_mask;
  } gate_cfg_t;

endpackage

// ===== rtl/core/sasm_item_if.sv =====
interface sasm_item_if import sasm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [MSG_W-1:0]     msg_type;
  logic                 header_ok;
  logic                 payload_ok;
  logic [SESSION_W-1:0] packet_session;
  logic [CLIENT_W-1:0]  client_ident;
  logic [CODEC_W-1:0]   codec_bits;
  logic [TIME_W-1:0]    now_us;

  modport source (
    output valid, operation, msg_type, header_ok, payload_ok, packet_session,
           client_ident, codec_bits, now_us,
    input  ready
  );
  modport sink (
    input  valid, operation, msg_type, header_ok, payload_ok, packet_session,
           client_ident, codec_bits, now_us,
    output ready
  );
endinterface

// ===== rtl/core/sasm_result_if.sv =====
interface sasm_result_if import sasm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic [ACTION_W-1:0]  action;
  logic [SESSION_W-1:0] current_session;
  logic [PHASE_W-1:0]   phase;

  modport source (
    output valid, accepted, action, current_session, phase,
    input  ready
  );
  modport sink (
    input  valid, accepted, action, current_session, phase,
    output ready
  );
endinterface

// ===== rtl/core/sasm_cfg_if.sv =====
interface sasm_cfg_if import sasm_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== rtl/core/sasm_decide.sv =====
module sasm_decide import sasm_pkg::*; (
  input  item_t          item,
  input  session_state_t state,
  input  gate_cfg_t      cfg,
  output session_state_t state_next,
  output result_t        result
);

  logic                 open;
  logic                 streaming;
  logic                 match;
  logic [TIME_W-1:0]    silence;
  logic                 expired;
  logic [SESSION_W-1:0] sid_raw;
  logic [SESSION_W-1:0] sid;
  logic                 accepted;
  action_t              action;

  assign open      = state.phase != PH_IDLE;
  assign streaming = state.phase == PH_STREAM;
  assign match     = item.packet_session == state.session;

  // Silence since the last accepted packet, wrapping modulo the time width
  assign silence = item.now_us - state.last_rx;
  assign expired = silence > {{(TIME_W-TIMEOUT_W){1'b0}}, cfg.timeout_us};

  // Fold the time into the client id; zero is reserved for no session
  assign sid_raw = item.now_us[SESSION_W-1:0] ^ item.now_us[TIME_W-1:SESSION_W]
                 ^ item.client_ident;
  assign sid     = (sid_raw == '0) ? {{(SESSION_W-1){1'b0}}, 1'b1} : sid_raw;

  // Decide the transition and the action for one item
  always_comb begin
    state_next = state;
    accepted   = 1'b0;
    action     = ACT_NONE;
    if (item.operation == OP_TICK) begin
      if (open && expired) begin
        state_next.phase   = PH_IDLE;
        state_next.session = '0;
        state_next.client  = '0;
        action             = ACT_DISC;
      end
    end else if (item.header_ok) begin
      unique case (item.msg_type)
        MSG_HELLO: begin
          if (item.payload_ok) begin
            if (open && item.client_ident != state.client) begin
              action = ACT_REJECT;
            end else if (!open && (item.codec_bits & cfg.codec_mask) == '0) begin
              action = ACT_REJECT;
            end else begin
              if (!open) begin
                state_next.client  = item.client_ident;
                state_next.session = sid;
                state_next.phase   = PH_READY;
              end
              state_next.last_rx = item.now_us;
              action             = ACT_ACK;
              accepted           = 1'b1;
            end
          end
        end
        MSG_START: begin
          if (open && match) begin
            if (!streaming) begin
              state_next.phase = PH_STREAM;
              action           = ACT_START;
            end
            state_next.last_rx = item.now_us;
            accepted           = 1'b1;
          end
        end
        MSG_PING: begin
          if (open && match && item.payload_ok) begin
            state_next.last_rx = item.now_us;
            action             = ACT_PONG;
            accepted           = 1'b1;
          end
        end
        MSG_KEYFRAME: begin
          if (streaming && match) begin
            state_next.last_rx = item.now_us;
            action             = ACT_KEYFRAME;
            accepted           = 1'b1;
          end
        end
        MSG_INPUT: begin
          if (streaming && match) begin
            state_next.last_rx = item.now_us;
            action             = ACT_INPUT;
            accepted           = 1'b1;
          end
        end
        MSG_FOCUS: begin
          if (streaming && match) begin
            state_next.last_rx = item.now_us;
            action             = item.payload_ok ? ACT_FOCUS : ACT_NONE;
            accepted           = 1'b1;
          end
        end
        MSG_FEEDBACK: begin
          if (open && match) begin
            state_next.last_rx = item.now_us;
            action             = item.payload_ok ? ACT_FEEDBACK : ACT_NONE;
            accepted           = 1'b1;
          end
        end
        MSG_NACK: begin
          if (streaming && match) begin
            state_next.last_rx = item.now_us;
            action             = item.payload_ok ? ACT_NACK : ACT_NONE;
            accepted           = 1'b1;
          end
        end
        MSG_INVALIDATE: begin
          if (streaming && match) begin
            state_next.last_rx = item.now_us;
            action             = item.payload_ok ? ACT_INVALIDATE : ACT_NONE;
            accepted           = 1'b1;
          end
        end
        MSG_CLIPBOARD: begin
          if (streaming && match && item.payload_ok) begin
            state_next.last_rx = item.now_us;
            action             = ACT_CLIPBOARD;
            accepted           = 1'b1;
          end
        end
        MSG_BYE: begin
          // Drop the session but keep the receive time
          if (open && match) begin
            state_next.phase   = PH_IDLE;
            state_next.session = '0;
            state_next.client  = '0;
            action             = ACT_DISC;
          end
        end
        default: begin
          // Unknown message types are dropped silently
        end
      endcase
    end
  end

  assign result.accepted        = accepted;
  assign result.action          = action;
  assign result.current_session = state_next.session;
  assign result.phase           = state_next.phase;

endmodule

// ===== rtl/core/session_admission_state_machine_top.sv =====
// Session admission gate for one remote client. Each transfer on item is a
// pre-parsed packet header or a time tick; each gives exactly one transfer on
// result with the accepted flag, an action code, the session id and the phase
// after the step. Throughput is one item per clock cycle while result.ready
// stays high. An input register feeds a combinational update of the session
// state (the 64-bit silence subtract and compare sets the path), and a result
// register with its own valid lets the next item enter while a result waits;
// each item passes through the input register and then the result register.
// Configuration writes on cfg are always ready and take effect on the next
// item; write only while no item is in flight.
module session_admission_state_machine_top import sasm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  sasm_item_if.sink           item,
  sasm_result_if.source       result,
  sasm_cfg_if.sink            cfg
);

  gate_cfg_t      gate_cfg;
  session_state_t state;
  session_state_t state_next;
  item_t          item_word;
  item_t          held_item;
  logic           held_valid;
  result_t        step_result;
  result_t        out_result;
  logic           out_valid;
  logic           advance;

  // Move the held item into the result register when that slot frees
  assign advance    = held_valid && (!out_valid || result.ready);
  assign item.ready = !held_valid || advance;
  assign cfg.ready  = 1'b1;

  assign item_word.operation      = item.operation;
  assign item_word.msg_type       = item.msg_type;
  assign item_word.header_ok      = item.header_ok;
  assign item_word.payload_ok     = item.payload_ok;
  assign item_word.packet_session = item.packet_session;
  assign item_word.client_ident   = item.client_ident;
  assign item_word.codec_bits     = item.codec_bits;
  assign item_word.now_us         = item.now_us;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_cfg.timeout_us <= TIMEOUT_RESET;
      gate_cfg.codec_mask <= CODEC_MASK_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_TIMEOUT:    gate_cfg.timeout_us <= cfg.data[TIMEOUT_W-1:0];
        CFG_CODEC_MASK: gate_cfg.codec_mask <= cfg.data[CODEC_W-1:0];
        default: begin
          // Ignore writes beyond the register list
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      held_item <= item_word;
    end
  end

  sasm_decide u_decide (
    .item       (held_item),
    .state      (state),
    .cfg        (gate_cfg),
    .state_next (state_next),
    .result     (step_result)
  );

  // Session state advances together with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase   <= PH_IDLE;
      state.session <= '0;
      state.client  <= '0;
      state.last_rx <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign result.valid           = out_valid;
  assign result.accepted        = out_result.accepted;
  assign result.action          = out_result.action;
  assign result.current_session = out_result.current_session;
  assign result.phase           = out_result.phase;

  // An open session always carries a nonzero id, an idle one carries none
  assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_IDLE) == (state.session == '0))
    else $error("session id does not agree with phase");

  // Session state moves only when an item is retired
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("session state changed without an item");

  // A disconnect always leaves the gate idle with no session
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.action == ACT_DISC |->
      out_result.phase == PH_IDLE && out_result.current_session == '0)
    else $error("disconnect left a session open");

  // Rejects and disconnects never flag the packet as accepted
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_result.action == ACT_REJECT || out_result.action == ACT_DISC)
      |-> !out_result.accepted)
    else $error("rejected packet flagged as accepted");

  // The reported session matches the state after the step
  assert property (@(posedge clk) disable iff (rst)
    advance |=> out_result.current_session == state.session
      && out_result.phase == state.phase)
    else $error("result does not report the updated state");

endmodule

// ===== sim/session_admission_state_machine_top_tb.sv =====
module session_admission_state_machine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sasm_pkg::*;

  localparam int PHASE_ITEMS     = 66;
  localparam int SWEEP_STEPS     = 6;
  localparam int HOLD_OFF_CYCLES = 48;
  localparam int SETTLE_CYCLES   = 6;
  localparam int REPORT_LIMIT    = 10;

  logic clk;
  logic rst;

  sasm_item_if   item_bus ();
  sasm_result_if result_bus ();
  sasm_cfg_if    cfg_bus ();

  session_admission_state_machine_top DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  // Session state as the gate should hold it
  phase_t               gate_phase;
  logic [SESSION_W-1:0] gate_session;
  logic [CLIENT_W-1:0]  gate_client;
  logic [TIME_W-1:0]    gate_last_rx;
  logic [TIMEOUT_W-1:0] gate_timeout;
  logic [CODEC_W-1:0]   gate_codec_mask;

  result_t expected_verdicts[$];
  logic [TIME_W-1:0] wall_us;
  bit  steady_flow;
  bit  hold_off_req;
  int  verdict_errors;
  int  results_checked;
  int  items_sent;
  int  admits_seen;
  int  drops_seen;
  int  held_cycles;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic item_t mk_item(logic op, logic [MSG_W-1:0] msg, logic hdr, logic pay,
                                    logic [SESSION_W-1:0] sess, logic [CLIENT_W-1:0] cid,
                                    logic [CODEC_W-1:0] codecs, logic [TIME_W-1:0] now);
    item_t it;
    it.operation      = op;
    it.msg_type       = msg;
    it.header_ok      = hdr;
    it.payload_ok     = pay;
    it.packet_session = sess;
    it.client_ident   = cid;
    it.codec_bits     = codecs;
    it.now_us         = now;
    return it;
  endfunction

  function automatic result_t mk_res(logic acc, action_t act, logic [SESSION_W-1:0] sess,
                                     phase_t ph);
    result_t r;
    r.accepted        = acc;
    r.action          = act;
    r.current_session = sess;
    r.phase           = ph;
    return r;
  endfunction

  // Advance the session state by one item and return the verdict it gives
  function automatic result_t gate_predict(item_t it);
    result_t              r;
    logic                 open_s;
    logic                 stream_s;
    logic                 id_match;
    logic                 needs_open;
    logic [SESSION_W-1:0] sid;
    logic [TIME_W-1:0]    silence;
    r.accepted = 1'b0;
    r.action   = ACT_NONE;
    open_s     = (gate_phase != PH_IDLE);
    stream_s   = (gate_phase == PH_STREAM);
    id_match   = (it.packet_session == gate_session);
    needs_open = (it.msg_type == MSG_START) || (it.msg_type == MSG_PING) ||
                 (it.msg_type == MSG_FEEDBACK) || (it.msg_type == MSG_BYE);
    if (it.operation == OP_TICK) begin
      silence = it.now_us - gate_last_rx;
      if (open_s && silence > gate_timeout) begin
        gate_phase   = PH_IDLE;
        gate_session = '0;
        gate_client  = '0;
        r.action     = ACT_DISC;
      end
    end else if (it.header_ok) begin
      if (it.msg_type == MSG_HELLO) begin
        if (it.payload_ok) begin
          if (open_s && it.client_ident != gate_client) begin
            r.action = ACT_REJECT;
          end else if (!open_s && (it.codec_bits & gate_codec_mask) == '0) begin
            r.action = ACT_REJECT;
          end else begin
            // A fresh admission derives the id; a repeat only refreshes the time
            if (!open_s) begin
              sid = it.now_us[31:0] ^ it.now_us[63:32] ^ it.client_ident;
              if (sid == '0) sid = 1;
              gate_client  = it.client_ident;
              gate_session = sid;
              gate_phase   = PH_READY;
            end
            gate_last_rx = it.now_us;
            r.action     = ACT_ACK;
            r.accepted   = 1'b1;
          end
        end
      end else if (it.msg_type <= MSG_BYE &&
                   id_match && (needs_open ? open_s : stream_s)) begin
        r.accepted = 1'b1;
        case (it.msg_type)
          MSG_START: begin
            if (!stream_s) begin
              gate_phase = PH_STREAM;
              r.action   = ACT_START;
            end
          end
          MSG_PING: begin
            if (it.payload_ok) r.action = ACT_PONG;
            else r.accepted = 1'b0;
          end
          MSG_KEYFRAME:   r.action = ACT_KEYFRAME;
          MSG_INPUT:      r.action = ACT_INPUT;
          MSG_FOCUS:      if (it.payload_ok) r.action = ACT_FOCUS;
          MSG_FEEDBACK:   if (it.payload_ok) r.action = ACT_FEEDBACK;
          MSG_NACK:       if (it.payload_ok) r.action = ACT_NACK;
          MSG_INVALIDATE: if (it.payload_ok) r.action = ACT_INVALIDATE;
          MSG_CLIPBOARD: begin
            if (it.payload_ok) r.action = ACT_CLIPBOARD;
            else r.accepted = 1'b0;
          end
          default: begin
            // Bye: drop the session but keep the receive time
            gate_phase   = PH_IDLE;
            gate_session = '0;
            gate_client  = '0;
            r.action     = ACT_DISC;
            r.accepted   = 1'b0;
          end
        endcase
        if (r.accepted) gate_last_rx = it.now_us;
      end
    end
    r.current_session = gate_session;
    r.phase           = gate_phase;
    return r;
  endfunction

  // Mostly well-formed traffic aimed at the current session, with some noise
  function automatic item_t draw_session_item();
    item_t it;
    int    roll;
    logic  open_s;
    open_s  = (gate_phase != PH_IDLE);
    wall_us = wall_us + $urandom_range(0, 3000);
    roll    = $urandom_range(0, 99);
    if (roll < 12) begin
      return mk_item($urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 1),
                     $urandom_range(0, 1), $urandom, $urandom, $urandom_range(0, 255),
                     {$urandom, $urandom});
    end
    it.operation      = (roll < 30) ? OP_TICK : OP_PACKET;
    it.header_ok      = ($urandom_range(0, 19) != 0);
    it.payload_ok     = ($urandom_range(0, 7) != 0);
    it.packet_session = ($urandom_range(0, 9) == 0) ? $urandom : gate_session;
    it.client_ident   = (open_s && $urandom_range(0, 4) != 0) ? gate_client : $urandom;
    it.codec_bits     = $urandom_range(0, 255);
    roll = $urandom_range(0, 99);
    if (!open_s) begin
      if (roll < 70) it.msg_type = MSG_HELLO;
      else it.msg_type = $urandom_range(0, 15);
    end else if (gate_phase == PH_READY && roll < 40) begin
      it.msg_type = MSG_START;
    end else if (roll < 8) begin
      it.msg_type = MSG_HELLO;
    end else if (roll < 13) begin
      it.msg_type = MSG_BYE;
    end else if (roll < 16) begin
      it.msg_type = $urandom_range(11, 15);
    end else begin
      it.msg_type = $urandom_range(1, 9);
    end
    if (it.operation == OP_TICK) begin
      case ($urandom_range(0, 3))
        0:       it.now_us = gate_last_rx + gate_timeout - 1 + $urandom_range(0, 2);
        1:       it.now_us = wall_us;
        2:       it.now_us = gate_last_rx + $urandom_range(0, 50);
        default: it.now_us = {$urandom, $urandom};
      endcase
    end else begin
      it.now_us = wall_us;
    end
    return it;
  endfunction

  // Offer one item, hold it until the transfer, then log the verdict it owes
  task automatic push_item(input item_t it, input bit typed, input result_t want);
    result_t verdict;
    if (!steady_flow && $urandom_range(0, 99) < 19) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_bus.valid          <= 1'b1;
    item_bus.operation      <= it.operation;
    item_bus.msg_type       <= it.msg_type;
    item_bus.header_ok      <= it.header_ok;
    item_bus.payload_ok     <= it.payload_ok;
    item_bus.packet_session <= it.packet_session;
    item_bus.client_ident   <= it.client_ident;
    item_bus.codec_bits     <= it.codec_bits;
    item_bus.now_us         <= it.now_us;
    do @(posedge clk); while (!item_bus.ready);
    verdict = gate_predict(it);
    if (verdict.action == ACT_ACK) admits_seen++;
    if (verdict.action == ACT_DISC) drops_seen++;
    expected_verdicts.push_back(typed ? want : verdict);
    items_sent++;
  endtask

  // Leaves valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == CFG_TIMEOUT) gate_timeout = value;
    else if (idx == CFG_CODEC_MASK) gate_codec_mask = value[CODEC_W-1:0];
  endtask

  // Stop offering, wait for every owed verdict, then a settling margin
  task automatic settle();
    item_bus.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: random stalls, or a long hold-off when asked
  initial begin
    int hold_left;
    hold_left = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        held_cycles++;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= steady_flow || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  // Compare each result transfer with the oldest owed verdict
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_verdicts.size() == 0) begin
        verdict_errors++;
        if (verdict_errors <= REPORT_LIMIT)
          $display("%0t: result with nothing owed: acc %0b act %0d sess %h phase %0d",
                   $realtime, result_bus.accepted, result_bus.action,
                   result_bus.current_session, result_bus.phase);
      end else begin
        want = expected_verdicts.pop_front();
        results_checked++;
        if (result_bus.accepted !== want.accepted || result_bus.action !== want.action ||
            result_bus.current_session !== want.current_session ||
            result_bus.phase !== want.phase) begin
          verdict_errors++;
          if (verdict_errors <= REPORT_LIMIT)
            $display({"%0t: mismatch exp/got: acc %0b/%0b act %0d/%0d ",
                      "sess %h/%h phase %0d/%0d"}, $realtime,
                     want.accepted, result_bus.accepted, want.action, result_bus.action,
                     want.current_session, result_bus.current_session,
                     want.phase, result_bus.phase);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #400_000;
    $display("session_admission_state_machine_top_tb: FAIL");
    $finish;
  end

  initial begin
    item_t                it;
    item_t                directed_items[$];
    bit                   directed_typed[$];
    result_t              directed_wants[$];
    logic [TIMEOUT_W-1:0] sweep_timeout [0:SWEEP_STEPS-1];
    logic [CODEC_W-1:0]   sweep_mask [0:SWEEP_STEPS-1];
    int                   counted;
    bit                   paused;

    rst                     <= 1'b1;
    item_bus.valid          <= 1'b0;
    item_bus.operation      <= OP_PACKET;
    item_bus.msg_type       <= MSG_HELLO;
    item_bus.header_ok      <= 1'b0;
    item_bus.payload_ok     <= 1'b0;
    item_bus.packet_session <= '0;
    item_bus.client_ident   <= '0;
    item_bus.codec_bits     <= '0;
    item_bus.now_us         <= '0;
    cfg_bus.valid           <= 1'b0;
    cfg_bus.index           <= CFG_TIMEOUT;
    cfg_bus.data            <= '0;

    gate_phase      = PH_IDLE;
    gate_session    = '0;
    gate_client     = '0;
    gate_last_rx    = '0;
    gate_timeout    = TIMEOUT_RESET;
    gate_codec_mask = CODEC_MASK_RESET;
    steady_flow     = 1'b0;
    hold_off_req    = 1'b0;

    sweep_timeout = '{32'hFFFF_FFFF, 32'd1, 32'd0, 32'd2000, 32'd20000, TIMEOUT_RESET};
    sweep_mask    = '{8'hFF, 8'h01, 8'h80, 8'h00, 8'h0F, 8'hFF};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk through a session life and a re-admission, under reset settings
    directed_items = '{
      mk_item(OP_TICK,   MSG_HELLO, 1, 1, 0, 0, 0, '1),
      mk_item(OP_PACKET, MSG_HELLO, 0, 1, 0, 1, 8'hFF, 5),
      mk_item(OP_PACKET, MSG_HELLO, 1, 0, 0, 1, 8'hFF, 5),
      mk_item(OP_PACKET, MSG_HELLO, 1, 1, 0, 7, 8'hFE, 5),
      mk_item(OP_PACKET, MSG_HELLO, 1, 1, 0, 32'h1234_5678, 8'h01, 64'h1234_5678),
      mk_item(OP_PACKET, MSG_HELLO, 1, 1, 0, 32'hFFFF_FFFF, 8'hFF, 600),
      mk_item(OP_PACKET, MSG_HELLO, 1, 1, 9, 32'h1234_5678, 8'h00, 1000),
      mk_item(OP_PACKET, MSG_KEYFRAME, 1, 1, 1, 0, 0, 1500),
      mk_item(OP_PACKET, MSG_PING, 1, 1, 2, 0, 0, 1500),
      mk_item(OP_PACKET, MSG_PING, 1, 1, 1, 0, 0, 2000),
      mk_item(OP_PACKET, MSG_START, 1, 1, 1, 0, 0, 2000),
      mk_item(OP_PACKET, MSG_START, 1, 1, 1, 0, 0, 2000),
      mk_item(OP_PACKET, MSG_KEYFRAME, 1, 1, 1, 0, 0, 2000),
      mk_item(OP_PACKET, MSG_INPUT, 1, 0, 1, 0, 0, 2000),
      mk_item(OP_PACKET, MSG_FOCUS, 1, 1, 1, 0, 0, 2000),
      mk_item(OP_PACKET, MSG_FEEDBACK, 1, 1, 1, 0, 0, 2000),
      mk_item(OP_PACKET, MSG_NACK, 1, 1, 1, 0, 0, 2000),
      mk_item(OP_PACKET, MSG_INVALIDATE, 1, 0, 1, 0, 0, 2000),
      mk_item(OP_PACKET, MSG_CLIPBOARD, 1, 0, 1, 0, 0, 2000),
      mk_item(OP_PACKET, MSG_CLIPBOARD, 1, 1, 1, 0, 0, 2000),
      mk_item(OP_PACKET, 4'hF, 1, 1, 1, 0, 0, 2000),
      mk_item(OP_TICK,   MSG_HELLO, 0, 0, 0, 0, 0, 5002000),
      mk_item(OP_TICK,   MSG_HELLO, 0, 0, 0, 0, 0, 5002001),
      mk_item(OP_PACKET, MSG_HELLO, 1, 1, 0, 32'hFFFF_FFFF, 8'hFF, '1),
      mk_item(OP_TICK,   MSG_HELLO, 0, 0, 0, 0, 0, 4999999),
      mk_item(OP_PACKET, MSG_BYE, 1, 0, 32'hFFFF_FFFF, 0, 0, 1)
    };
    // Hand-typed verdicts where they are obvious; the rest come from the predictor
    directed_typed = '{1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0,
                       0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1, 0, 1};
    directed_wants = '{
      mk_res(0, ACT_NONE, 0, PH_IDLE),
      mk_res(0, ACT_NONE, 0, PH_IDLE),
      mk_res(0, ACT_NONE, 0, PH_IDLE),
      mk_res(0, ACT_REJECT, 0, PH_IDLE),
      mk_res(1, ACT_ACK, 1, PH_READY),
      mk_res(0, ACT_REJECT, 1, PH_READY),
      mk_res(1, ACT_ACK, 1, PH_READY),
      '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0,
      mk_res(0, ACT_NONE, 1, PH_STREAM),
      '0,
      mk_res(0, ACT_DISC, 0, PH_IDLE),
      mk_res(1, ACT_ACK, 32'hFFFF_FFFF, PH_READY),
      '0,
      mk_res(0, ACT_DISC, 0, PH_IDLE)
    };
    foreach (directed_items[i])
      push_item(directed_items[i], directed_typed[i], directed_wants[i]);
    settle();

    // Random traffic across a sweep of register settings
    for (int step = 0; step < SWEEP_STEPS; step++) begin
      write_reg(CFG_TIMEOUT, sweep_timeout[step]);
      write_reg(CFG_CODEC_MASK, CFG_DATA_W'(sweep_mask[step]));
      cfg_bus.valid <= 1'b0;
      wall_us     = {$urandom, $urandom};
      steady_flow = (step == 2);
      // Back up the result side while items keep coming
      if (step == 2) hold_off_req = 1'b1;
      counted = 0;
      paused  = 1'b0;
      while (counted < PHASE_ITEMS) begin
        if (step == 3 && !paused && counted == PHASE_ITEMS / 2) begin
          paused = 1'b1;
          settle();
        end
        it = draw_session_item();
        push_item(it, 1'b0, '0);
        if (!(it.operation == OP_PACKET && !it.header_ok)) counted++;
      end
      settle();
    end
    steady_flow = 1'b0;

    $display("Sent %0d items (%0d directed, rest random over %0d register settings); %0d checked.",
             items_sent, directed_items.size(), SWEEP_STEPS, results_checked);
    $display("Admissions acked %0d, sessions dropped %0d, result side held off %0d cycles.",
             admits_seen, drops_seen, held_cycles);
    if (verdict_errors == 0 && expected_verdicts.size() == 0) begin
      $display("session_admission_state_machine_top_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d verdicts still owed.", verdict_errors,
               expected_verdicts.size());
      $display("session_admission_state_machine_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sasm_pkg.sv
rtl/core/sasm_item_if.sv
rtl/core/sasm_result_if.sv
rtl/core/sasm_cfg_if.sv
rtl/core/sasm_decide.sv
rtl/core/session_admission_state_machine_top.sv
sim/session_admission_state_machine_top_tb.sv
